/* rtl/sao_pkg.sv */
// Shared types and constants for the straight-alpha over-blend pipeline.
package sao_pkg;

  localparam int unsigned ChanW  = 8;
  localparam int unsigned NChan  = 3;
  localparam int unsigned WgtW   = 16;                // combined weight, up to 255*255
  localparam int unsigned ProdW  = 2 * ChanW;         // 8x8 product
  localparam int unsigned NumW   = 3 * ChanW;         // numerator, at most 255 * weight
  localparam int unsigned DivSteps = ChanW;           // one quotient bit per stage

  localparam logic [ChanW-1:0] ChanMax = 8'hFF;
  localparam logic [WgtW-1:0]  WgtMax  = 16'd65025;

  typedef logic [ChanW-1:0] chan_t;

  // Data that rides alongside the blend math: bypass select and final alpha.
  typedef struct packed {
    logic                  byp;
    logic [NChan-1:0][ChanW-1:0] byp_rgb;
    chan_t                 alpha;
  } side_t;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
    chan_t alpha;
  } pix_t;

  typedef struct packed {
    pix_t src;
    pix_t dst;
  } pair_t;

  // After the first multiply stage.
  typedef struct packed {
    side_t                       side;
    logic [NChan-1:0][ProdW-1:0] dprod;   // dst_c * dst_alpha
    logic [NChan-1:0][ProdW-1:0] sprod;   // src_c * src_alpha
    chan_t                       nsa;     // 255 - src_alpha
    logic [WgtW-1:0]             wgt;
  } mul_t;

  // Divider working set, one partial remainder and quotient per color.
  typedef struct packed {
    side_t                       side;
    logic [WgtW-1:0]             wgt;
    logic [NChan-1:0][NumW-1:0]  rem;
    logic [NChan-1:0][ChanW-1:0] quo;
  } div_t;

endpackage

/* rtl/sao_mul_stage.sv */
// First stage: per-channel alpha products, combined weight, bypass select.
module sao_mul_stage
  import sao_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  up_v,
  input  pair_t up_d,
  input  logic  dn_rdy,
  output logic  up_rdy,
  output logic  v_r,
  output mul_t  d_r
);

  mul_t  d_nxt;
  chan_t nda;
  chan_t sc [NChan];
  chan_t dc [NChan];

  assign up_rdy = !v_r || dn_rdy;

  always_comb begin
    sc[0] = up_d.src.red;
    sc[1] = up_d.src.green;
    sc[2] = up_d.src.blue;
    dc[0] = up_d.dst.red;
    dc[1] = up_d.dst.green;
    dc[2] = up_d.dst.blue;
    nda         = ChanMax - up_d.dst.alpha;
    d_nxt.nsa   = ChanMax - up_d.src.alpha;
    d_nxt.wgt   = WgtMax - (ProdW'(d_nxt.nsa) * ProdW'(nda));
    for (int i = 0; i < NChan; i++) begin
      d_nxt.dprod[i] = ProdW'(dc[i]) * ProdW'(up_d.dst.alpha);
      d_nxt.sprod[i] = ProdW'(sc[i]) * ProdW'(up_d.src.alpha);
    end
    // transparent source passes the destination, else transparent dst copies source
    d_nxt.side.byp = (up_d.src.alpha == '0) || (up_d.dst.alpha == '0);
    if (up_d.src.alpha == '0) begin
      d_nxt.side.byp_rgb = {up_d.dst.red, up_d.dst.green, up_d.dst.blue};
      d_nxt.side.alpha   = up_d.dst.alpha;
    end else begin
      d_nxt.side.byp_rgb = {up_d.src.red, up_d.src.green, up_d.src.blue};
      d_nxt.side.alpha   = up_d.src.alpha;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_rdy) begin
      v_r <= up_v;
    end
  end

  always_ff @(posedge clk) begin
    if (up_rdy && up_v) begin
      d_r <= d_nxt;
    end
  end

endmodule

/* rtl/sao_sum_stage.sv */
// Second stage: blend numerators and combined alpha (weight / 255).
module sao_sum_stage
  import sao_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic up_v,
  input  mul_t up_d,
  input  logic dn_rdy,
  output logic up_rdy,
  output logic v_r,
  output div_t d_r
);

  div_t              d_nxt;
  logic [NumW:0]     num;
  logic [WgtW:0]     asum;

  assign up_rdy = !v_r || dn_rdy;

  always_comb begin
    d_nxt.wgt  = up_d.wgt;
    d_nxt.side = up_d.side;
    for (int i = 0; i < NChan; i++) begin
      // sprod * 255 as (sprod << 8) - sprod
      num = (NumW+1)'(up_d.dprod[i]) * (NumW+1)'(up_d.nsa)
          + ((NumW+1)'(up_d.sprod[i]) << ChanW) - (NumW+1)'(up_d.sprod[i]);
      d_nxt.rem[i] = num[NumW-1:0];
      d_nxt.quo[i] = '0;
    end
    // exact floor(x / 255) for 16-bit x: (x + (x >> 8) + 1) >> 8
    asum = (WgtW+1)'(up_d.wgt) + (WgtW+1)'(up_d.wgt >> ChanW) + (WgtW+1)'(1);
    if (!up_d.side.byp) begin
      d_nxt.side.alpha = asum[ChanW +: ChanW];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_rdy) begin
      v_r <= up_v;
    end
  end

  always_ff @(posedge clk) begin
    if (up_rdy && up_v) begin
      d_r <= d_nxt;
    end
  end

endmodule

/* rtl/sao_div_stage.sv */
// One restoring-division step: one quotient bit per color channel.
module sao_div_stage
  import sao_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic up_v,
  input  div_t up_d,
  input  logic dn_rdy,
  output logic up_rdy,
  output logic v_r,
  output div_t d_r
);

  div_t                   d_nxt;
  logic [NumW-2:0]        dsh;
  logic [NumW-1:0]        diff;
  logic                   ge;

  assign up_rdy = !v_r || dn_rdy;

  // Remainder stays below weight << 8; compare against weight << 7, then double.
  always_comb begin
    d_nxt = up_d;
    dsh   = {up_d.wgt, (ChanW-1)'(0)};
    for (int i = 0; i < NChan; i++) begin
      ge   = up_d.rem[i] >= NumW'(dsh);
      diff = ge ? up_d.rem[i] - NumW'(dsh) : up_d.rem[i];
      d_nxt.rem[i] = {diff[NumW-2:0], 1'b0};
      d_nxt.quo[i] = {up_d.quo[i][ChanW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_rdy) begin
      v_r <= up_v;
    end
  end

  always_ff @(posedge clk) begin
    if (up_rdy && up_v) begin
      d_r <= d_nxt;
    end
  end

endmodule

/* rtl/straight_alpha_over_blend_top.sv */
// Top level of the straight-alpha Porter-Duff over blend pipeline.
//
//   channel | ports                               | direction | word
//   input   | in_valid, in_stall, in_src_*, in_dst_* | in     | src + dst RGBA8 pair
//   result  | out_valid, out_stall, out_*         | out       | blended RGBA8 pixel
//
// Ten register stages: products, numerators, then eight divide steps.
// One word in per cycle while out_stall does not hold the pipeline; out_valid
// rises once the word has passed the product, numerator and divide stages.
// The divide chain (one quotient bit per stage) sets the depth.
// rst_n (synchronous) empties every stage; payload registers are not reset.
// Each stage holds while its successor is full and stalled, so a stall on
// out_stall backs up only as far as the pipeline is full; bubbles are squeezed.
module straight_alpha_over_blend_top
  import sao_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_stall,
  input  chan_t in_src_red,
  input  chan_t in_src_green,
  input  chan_t in_src_blue,
  input  chan_t in_src_alpha,
  input  chan_t in_dst_red,
  input  chan_t in_dst_green,
  input  chan_t in_dst_blue,
  input  chan_t in_dst_alpha,
  output logic  out_valid,
  input  logic  out_stall,
  output chan_t out_red,
  output chan_t out_green,
  output chan_t out_blue,
  output chan_t out_alpha
);

  pair_t pair;
  logic  mul_rdy;
  logic  mul_v;
  mul_t  mul_d;
  logic  sum_rdy;

  // divide chain: index 0 is the sum stage output, DivSteps the last divide step
  logic  div_v   [DivSteps+1];
  div_t  div_d   [DivSteps+1];
  logic  div_rdy [DivSteps+1];    // ready of the stage consuming div_d[k]

  assign pair.src = '{red: in_src_red, green: in_src_green,
                      blue: in_src_blue, alpha: in_src_alpha};
  assign pair.dst = '{red: in_dst_red, green: in_dst_green,
                      blue: in_dst_blue, alpha: in_dst_alpha};

  assign in_stall = !mul_rdy;

  sao_mul_stage u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .up_v   (in_valid),
    .up_d   (pair),
    .dn_rdy (sum_rdy),
    .up_rdy (mul_rdy),
    .v_r    (mul_v),
    .d_r    (mul_d)
  );

  sao_sum_stage u_sum (
    .clk    (clk),
    .rst_n  (rst_n),
    .up_v   (mul_v),
    .up_d   (mul_d),
    .dn_rdy (div_rdy[0]),
    .up_rdy (sum_rdy),
    .v_r    (div_v[0]),
    .d_r    (div_d[0])
  );

  for (genvar k = 0; k < DivSteps; k++) begin : g_div
    sao_div_stage u_div (
      .clk    (clk),
      .rst_n  (rst_n),
      .up_v   (div_v[k]),
      .up_d   (div_d[k]),
      .dn_rdy (div_rdy[k+1]),
      .up_rdy (div_rdy[k]),
      .v_r    (div_v[k+1]),
      .d_r    (div_d[k+1])
    );
  end

  assign div_rdy[DivSteps] = !out_stall;

  // Final select: bypass words carry their pixel, blended words the quotients.
  // Quotients never exceed 255 since the numerator is below 256 * weight,
  // so the 8-bit quotient is already saturated.
  assign out_valid = div_v[DivSteps];
  assign out_red   = div_d[DivSteps].side.byp ? div_d[DivSteps].side.byp_rgb[2]
                                              : div_d[DivSteps].quo[0];
  assign out_green = div_d[DivSteps].side.byp ? div_d[DivSteps].side.byp_rgb[1]
                                              : div_d[DivSteps].quo[1];
  assign out_blue  = div_d[DivSteps].side.byp ? div_d[DivSteps].side.byp_rgb[0]
                                              : div_d[DivSteps].quo[2];
  assign out_alpha = div_d[DivSteps].side.alpha;

endmodule

/* rtl/sao_chk.sv */
// Port-level checker for the over-blend pipeline, bound to the top level.
module sao_chk
  import sao_pkg::*;
(
  input logic  clk,
  input logic  rst_n,
  input logic  in_stall,
  input logic  out_valid,
  input logic  out_stall,
  input chan_t out_red,
  input chan_t out_green,
  input chan_t out_blue,
  input chan_t out_alpha
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_red) && $stable(out_green)
                               && $stable(out_blue) && $stable(out_alpha))
    else $error("stalled result word changed");

  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with free output");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("pipeline not empty after reset");

endmodule

bind straight_alpha_over_blend_top sao_chk u_sao_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_red   (out_red),
  .out_green (out_green),
  .out_blue  (out_blue),
  .out_alpha (out_alpha)
);

/* tb/tb_straight_alpha_over_blend_top.sv */
// Testbench for the straight-alpha over-blend pipeline: scoreboard class and stimulus.
module tb_straight_alpha_over_blend_top
  import sao_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // Random words after the directed set.
  localparam int unsigned RandomWords = 1100;
  // Cycles with no word moved on either side before the run is called hung.
  // The slowest legal stretch is one receiver hold-off plus a sender gap.
  localparam int unsigned IdleLimit   = 1000;
  // Receiver hold-off length; far more than the ten pipeline stages.
  localparam int unsigned HoldOff     = 60;
  // Cycles to keep watching after the last expected pixel, past the latency.
  localparam int unsigned DrainCycles = 30;
  localparam int unsigned ReportMax   = 10;

  // Holds predicted pixels in acceptance order and checks each one leaving
  // the block against the oldest.
  class over_blend_board;
    pix_t        pending[$];
    int unsigned errors;

    function new();
      errors = 0;
    endfunction

    // One color channel of the blend case: weighted sum over combined weight,
    // truncated and clamped.
    function chan_t mix_channel(chan_t sc, chan_t sa, chan_t dc, chan_t da,
                                int unsigned wgt);
      int unsigned num;
      int unsigned quo;
      num = int'(dc) * int'(da) * (int'(ChanMax) - int'(sa))
          + int'(sc) * int'(sa) * int'(ChanMax);
      quo = num / wgt;
      if (quo > int'(ChanMax)) quo = int'(ChanMax);
      return chan_t'(quo);
    endfunction

    function pix_t predict_over(pair_t p);
      pix_t        res;
      int unsigned wgt;
      if (p.src.alpha == '0) begin
        res = p.dst;
      end else if (p.dst.alpha == '0) begin
        res = p.src;
      end else begin
        wgt = int'(WgtMax)
            - (int'(ChanMax) - int'(p.src.alpha)) * (int'(ChanMax) - int'(p.dst.alpha));
        res.red   = mix_channel(p.src.red,   p.src.alpha, p.dst.red,   p.dst.alpha, wgt);
        res.green = mix_channel(p.src.green, p.src.alpha, p.dst.green, p.dst.alpha, wgt);
        res.blue  = mix_channel(p.src.blue,  p.src.alpha, p.dst.blue,  p.dst.alpha, wgt);
        res.alpha = chan_t'(wgt / int'(ChanMax));
      end
      return res;
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= ReportMax) $display("%s", msg);
    endfunction

    function void note_pair(pair_t p);
      pending.push_back(predict_over(p));
    endfunction

    function void check_pixel(pix_t got);
      pix_t want;
      if (pending.size() == 0) begin
        flag($sformatf("ERROR: pixel with none expected: rgba %h %h %h %h",
                       got.red, got.green, got.blue, got.alpha));
        return;
      end
      want = pending.pop_front();
      if (got.red !== want.red || got.green !== want.green ||
          got.blue !== want.blue || got.alpha !== want.alpha)
        flag($sformatf("ERROR: pixel mismatch: expected rgba %h %h %h %h, got %h %h %h %h",
                       want.red, want.green, want.blue, want.alpha,
                       got.red, got.green, got.blue, got.alpha));
    endfunction
  endclass

  logic  clk = 1'b0;
  logic  rst_n;
  logic  in_valid;
  logic  in_stall;
  pair_t drive_pair;
  logic  out_valid;
  logic  out_stall;
  chan_t out_red;
  chan_t out_green;
  chan_t out_blue;
  chan_t out_alpha;

  over_blend_board board;
  int unsigned     idle_cycles;

  straight_alpha_over_blend_top uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_src_red   (drive_pair.src.red),
    .in_src_green (drive_pair.src.green),
    .in_src_blue  (drive_pair.src.blue),
    .in_src_alpha (drive_pair.src.alpha),
    .in_dst_red   (drive_pair.dst.red),
    .in_dst_green (drive_pair.dst.green),
    .in_dst_blue  (drive_pair.dst.blue),
    .in_dst_alpha (drive_pair.dst.alpha),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_red      (out_red),
    .out_green    (out_green),
    .out_blue     (out_blue),
    .out_alpha    (out_alpha)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic pair_t make_pair(chan_t sr, chan_t sg, chan_t sb, chan_t sa,
                                      chan_t dr, chan_t dg, chan_t db, chan_t da);
    pair_t p;
    p.src = '{red: sr, green: sg, blue: sb, alpha: sa};
    p.dst = '{red: dr, green: dg, blue: db, alpha: da};
    return p;
  endfunction

  // Alpha drawn from the corners more often than a flat draw would.
  function automatic chan_t pick_alpha();
    case ($urandom_range(3))
      0:       return chan_t'($urandom_range(1, 3));
      1:       return chan_t'($urandom_range(252, 255));
      default: return chan_t'($urandom_range(1, 255));
    endcase
  endfunction

  // Random pixel pair; the two pass-through cases get a fair share so the
  // bypass path sees plenty of traffic next to the blend math.
  function automatic pair_t random_pair();
    pair_t p;
    p = pair_t'({$urandom, $urandom});
    case ($urandom_range(9))
      0, 1: p.src.alpha = '0;                      // transparent source
      2, 3: begin                                  // transparent destination
        p.src.alpha = pick_alpha();
        p.dst.alpha = '0;
      end
      4, 5: begin
        p.src.alpha = pick_alpha();
        p.dst.alpha = pick_alpha();
      end
      default: ;                                   // flat random, any alpha
    endcase
    // Now and then push colors to the rails.
    if ($urandom_range(7) == 0) begin
      p.src.red  = '1;
      p.dst.blue = '0;
    end
    return p;
  endfunction

  // Offer one word from the falling edge and hold it until a rising edge
  // finds in_stall low. Valid stays up on return so a burst runs gap-free.
  task automatic push_pair(input pair_t p);
    @(negedge clk);
    in_valid   <= 1'b1;
    drive_pair <= p;
    do @(posedge clk); while (in_stall);
    board.note_pair(p);
  endtask

  // Sender gap set by n; valid drops on the first falling edge.
  task automatic rest_sender(input int unsigned n);
    if (n == 0) return;
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // Random gap between bursts, sometimes no gap at all.
  task automatic send_burst_gap();
    if ($urandom_range(2) != 0) rest_sender($urandom_range(1, 8));
  endtask

  // Result side: check every pixel taken, and watch for a hung pipeline.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall)
        board.check_pixel('{red: out_red, green: out_green,
                            blue: out_blue, alpha: out_alpha});
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("tb_straight_alpha_over_blend_top: done, errors");
        $finish;
      end
    end
  end

  // Receiver stall pattern, cycling through four moods: free-running,
  // a long hold-off (fills the pipe and pushes back on the sender while it
  // keeps offering), a random 40% stall, and a fixed 2-of-5 stall.
  initial begin
    int unsigned mood;
    int unsigned n;
    out_stall = 1'b0;
    mood = 0;
    wait (rst_n === 1'b1);
    forever begin
      n = $urandom_range(20, 120);
      case (mood % 4)
        0: begin
          @(negedge clk);
          out_stall <= 1'b0;
          repeat (n - 1) @(negedge clk);
        end
        1: begin
          @(negedge clk);
          out_stall <= 1'b1;
          repeat (HoldOff - 1) @(negedge clk);
        end
        2: begin
          repeat (n) begin
            @(negedge clk);
            out_stall <= ($urandom_range(99) < 40);
          end
        end
        default: begin
          for (int unsigned k = 0; k < n; k++) begin
            @(negedge clk);
            out_stall <= ((k % 5) < 2);
          end
        end
      endcase
      mood++;
    end
  end

  // Main sequence: reset, directed pairs, random bursts, drain, verdict.
  initial begin
    pair_t       directed[$];
    int unsigned sent;
    int unsigned run_len;

    board       = new();
    idle_cycles = 0;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    drive_pair  = '0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Transparent source: destination passes through, alpha 0 included.
    directed.push_back(make_pair(8'd10, 8'd20, 8'd30, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255));
    directed.push_back(make_pair(8'd255, 8'd255, 8'd255, 8'd0, 8'd1, 8'd2, 8'd3, 8'd0));
    directed.push_back(make_pair(8'd0, 8'd0, 8'd0, 8'd0, 8'h5A, 8'hA5, 8'h3C, 8'h80));
    // Transparent destination: source copied.
    directed.push_back(make_pair(8'd255, 8'd0, 8'd255, 8'd255, 8'd9, 8'd9, 8'd9, 8'd0));
    directed.push_back(make_pair(8'd200, 8'd100, 8'd50, 8'd1, 8'd0, 8'd0, 8'd0, 8'd0));
    // Opaque source over opaque destination.
    directed.push_back(make_pair(8'd12, 8'd34, 8'd56, 8'd255, 8'd200, 8'd200, 8'd200, 8'd255));
    // Smallest divisor: both alphas 1.
    directed.push_back(make_pair(8'd255, 8'd255, 8'd255, 8'd1, 8'd255, 8'd255, 8'd255, 8'd1));
    directed.push_back(make_pair(8'd0, 8'd0, 8'd0, 8'd1, 8'd0, 8'd0, 8'd0, 8'd1));
    directed.push_back(make_pair(8'd255, 8'd0, 8'd128, 8'd1, 8'd0, 8'd255, 8'd128, 8'd255));
    directed.push_back(make_pair(8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd1));
    directed.push_back(make_pair(8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255, 8'd1));
    directed.push_back(make_pair(8'd128, 8'd64, 8'd32, 8'd128, 8'd16, 8'd8, 8'd4, 8'd128));
    // Rails: everything full, then colors zero at full alpha.
    directed.push_back(make_pair(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255));
    directed.push_back(make_pair(8'd0, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd0, 8'd255));
    // Near-opaque pair; saturation edge with bright colors on both sides.
    directed.push_back(make_pair(8'd255, 8'd255, 8'd255, 8'd254, 8'd255, 8'd255, 8'd255, 8'd254));
    directed.push_back(make_pair(8'hAA, 8'h55, 8'hAA, 8'd127, 8'h55, 8'hAA, 8'h55, 8'd200));
    directed.push_back(make_pair(8'h55, 8'hAA, 8'h55, 8'd200, 8'hAA, 8'h55, 8'hAA, 8'd127));
    directed.push_back(make_pair(8'd255, 8'd1, 8'd254, 8'd2, 8'd1, 8'd255, 8'd2, 8'd253));
    directed.push_back(make_pair(8'd17, 8'd240, 8'd99, 8'd253, 8'd250, 8'd3, 8'd77, 8'd2));

    foreach (directed[i]) begin
      push_pair(directed[i]);
      if ($urandom_range(3) == 0) rest_sender($urandom_range(1, 4));
    end

    // Random bursts. The hold-off in the receiver lands somewhere inside
    // these, so the pipe fills while words are still being offered.
    sent = 0;
    while (sent < RandomWords) begin
      run_len = $urandom_range(1, 40);
      for (int unsigned k = 0; k < run_len && sent < RandomWords; k++) begin
        push_pair(random_pair());
        sent++;
      end
      send_burst_gap();
    end
    rest_sender(1);

    // Drain; a stuck pipe is caught by the watchdog.
    while (board.pending.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (board.errors == 0)
      $display("tb_straight_alpha_over_blend_top: done, clean");
    else
      $display("tb_straight_alpha_over_blend_top: done, errors");
    $finish;
  end

endmodule
